// File: hw/rtl/deef_pkg.sv
// ----------------------------------------------------------------------------
// Debounced edge event queue package
// Shared command codes and the stored event format.
// ----------------------------------------------------------------------------
package deef_pkg;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_EDGE = 2'd1,
		CMD_POP  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_e_t;

	localparam int TIME_W    = 32;
	localparam int LOCKOUT_W = 16;
	localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd50;

	typedef struct packed {
		logic              level;
		logic [TIME_W-1:0] stamp;
	} event_slot_t;

endpackage

// File: hw/rtl/debounced_edge_event_fifo_top.sv
// ----------------------------------------------------------------------------
// Debounced edge event queue
// Millisecond clock, level-change debounce and a ring queue of stamped events.
// ----------------------------------------------------------------------------
// The block takes one item in every cycle and never raises busy. Each item
// gives exactly one result, shown on the result ports with done high for one
// cycle. An item passes through the input register, where the state update
// and the queue write or read happen, and then through the result register,
// which also holds the registered queue read data. The receiver cannot stall.
// The lockout register may be written at any time (cfg_ready is always high)
// but should only change while no item is in flight. The queue holds at most
// QUEUE_DEPTH - 1 events.
module debounced_edge_event_fifo_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         command,
	input  logic                               pin_level,
	output logic                               done,
	output logic                               event_valid,
	output logic                               event_level,
	output logic [deef_pkg::TIME_W-1:0]        event_time,
	output logic                               edge_accepted,
	output logic                               queue_full,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [deef_pkg::LOCKOUT_W-1:0]     cfg_data
);
	import deef_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	// Input register
	logic        valid_s1;
	cmd_e_t      cmd_s1;
	logic        level_s1;

	// Architectural state
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic                 acc_level_q;
	logic [TIME_W-1:0]    last_time_q;
	logic [TIME_W-1:0]    now_q;
	logic [LOCKOUT_W-1:0] lockout_q;

	// Result register
	logic        done_s2;
	logic        pop_s2;
	logic        accept_s2;
	logic        full_s2;
	event_slot_t rdata_s2;

	event_slot_t mem [QUEUE_DEPTH];

	logic [PTR_W-1:0]  wr_next;
	logic [PTR_W-1:0]  rd_next;
	logic              is_full;
	logic              is_empty;
	logic [TIME_W-1:0] elapsed;
	logic              lock_ok;
	logic              do_tick;
	logic              do_accept;
	logic              do_drop;
	logic              do_pop;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	assign wr_next  = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next  = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
	assign is_full  = (wr_next == rd_ptr_q);
	assign is_empty = (wr_ptr_q == rd_ptr_q);
	assign elapsed  = now_q - last_time_q;
	assign lock_ok  = (elapsed > {{(TIME_W-LOCKOUT_W){1'b0}}, lockout_q});

	always_comb begin
		do_tick   = 1'b0;
		do_accept = 1'b0;
		do_drop   = 1'b0;
		do_pop    = 1'b0;
		if (valid_s1) begin
			case (cmd_s1)
				CMD_TICK: do_tick = 1'b1;
				CMD_EDGE: begin
					// A full queue drops the edge before the debounce checks apply.
					do_drop   = is_full;
					do_accept = !is_full && (level_s1 != acc_level_q) && lock_ok;
				end
				CMD_POP:  do_pop = !is_empty;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cmd_s1   <= CMD_NONE;
		end else begin
			valid_s1 <= start && !busy;
			cmd_s1   <= cmd_e_t'(command);
		end
	end

	always_ff @(posedge clk) begin
		level_s1 <= pin_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			acc_level_q <= 1'b0;
			last_time_q <= '0;
			now_q       <= '0;
			lockout_q   <= LOCKOUT_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				lockout_q <= cfg_data;
			end
			if (do_tick) begin
				now_q <= now_q + 1'b1;
			end
			if (do_accept) begin
				wr_ptr_q    <= wr_next;
				acc_level_q <= level_s1;
				last_time_q <= now_q;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_accept) begin
			mem[wr_ptr_q] <= '{level: level_s1, stamp: now_q};
		end
		if (do_pop) begin
			rdata_s2 <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2   <= 1'b0;
			pop_s2    <= 1'b0;
			accept_s2 <= 1'b0;
			full_s2   <= 1'b0;
		end else begin
			done_s2   <= valid_s1;
			pop_s2    <= do_pop;
			accept_s2 <= do_accept;
			full_s2   <= do_drop;
		end
	end

	assign done          = done_s2;
	assign event_valid   = pop_s2;
	assign event_level   = pop_s2 & rdata_s2.level;
	assign event_time    = pop_s2 ? rdata_s2.stamp : '0;
	assign edge_accepted = accept_s2;
	assign queue_full    = full_s2;

	// At most one kind of result flag is raised for an item.
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({pop_s2, accept_s2, full_s2}))
		else $error("more than one result flag raised");

	// Flags only show together with the done strobe.
	a_flag_done: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_s2 || accept_s2 || full_s2) |-> done_s2)
		else $error("result flag without done");

	// An accepted edge never fills the last free slot of the ring.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		do_accept |=> (wr_ptr_q != rd_ptr_q))
		else $error("queue write pointer caught up with read pointer");

	// A pop of an empty queue returns no event.
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cmd_s1 == CMD_POP && is_empty) |=> !event_valid)
		else $error("event returned from an empty queue");

	// Every result comes from an item held in the input register.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_s2 |-> $past(valid_s1))
		else $error("done without a preceding item");

endmodule

// File: bench/tb_debounced_edge_event_fifo_top.sv
// ----------------------------------------------------------------------------
// Debounced edge event queue testbench
// Drives tick, edge, pop and unused commands through the command port and
// checks every result against a local model of the millisecond clock, the
// lockout debounce and the event ring. The lockout register is changed
// between traffic phases, each phase with a short lockout opening with a
// boundary probe.
// ----------------------------------------------------------------------------
module tb_debounced_edge_event_fifo_top;

	import deef_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		cmd_e_t cmd;
		logic   pin;
	} stim_t;

	typedef struct packed {
		logic              valid;
		logic              level;
		logic [TIME_W-1:0] stamp;
		logic              accepted;
		logic              full;
	} report_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [1:0]           command = CMD_TICK;
	logic                 pin_level = 1'b0;
	logic                 done;
	logic                 event_valid;
	logic                 event_level;
	logic [TIME_W-1:0]    event_time;
	logic                 edge_accepted;
	logic                 queue_full;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [LOCKOUT_W-1:0] cfg_data = '0;

	// Local copy of the block state.
	logic [TIME_W-1:0]    clock_ms = '0;
	logic [TIME_W-1:0]    last_take_ms = '0;
	logic                 held_level = 1'b0;
	logic [LOCKOUT_W-1:0] lockout_now = LOCKOUT_RESET;
	event_slot_t          ring [QUEUE_DEPTH];
	int unsigned          wr_ptr = 0;
	int unsigned          rd_ptr = 0;

	stim_t                pending_items [$];
	report_t              reports_due [$];
	stim_t                next_item;
	report_t              got_report;
	report_t              want_report;
	int unsigned          sender_idle_pct = 24;
	int unsigned          mismatches = 0;
	int unsigned          cycle_count = 0;

	int unsigned lockout_plan [5] = '{1, 20, 7, 65535, 50};
	int unsigned idle_plan [5] = '{24, 57, 57, 0, 0};

	debounced_edge_event_fifo_top #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.pin_level(pin_level),
		.done(done),
		.event_valid(event_valid),
		.event_level(event_level),
		.event_time(event_time),
		.edge_accepted(edge_accepted),
		.queue_full(queue_full),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Advances the local state by one item and records the result it must give.
	task automatic apply_debounce_item(cmd_e_t cmd, logic pin);
		report_t     r;
		int unsigned nxt;
		r = '0;
		case (cmd)
			CMD_TICK: begin
				clock_ms = clock_ms + 1;
			end
			CMD_EDGE: begin
				nxt = (wr_ptr + 1) % QUEUE_DEPTH;
				if (nxt == rd_ptr) begin
					r.full = 1'b1;
				end else if (pin != held_level &&
						(clock_ms - last_take_ms) > {16'd0, lockout_now}) begin
					ring[wr_ptr] = '{level: pin, stamp: clock_ms};
					wr_ptr = nxt;
					last_take_ms = clock_ms;
					held_level = pin;
					r.accepted = 1'b1;
				end
			end
			CMD_POP: begin
				if (rd_ptr != wr_ptr) begin
					r.valid = 1'b1;
					r.level = ring[rd_ptr].level;
					r.stamp = ring[rd_ptr].stamp;
					rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
				end
			end
			default: begin
			end
		endcase
		reports_due.push_back(r);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic push_item(cmd_e_t cmd, logic pin);
		pending_items.push_back('{cmd: cmd, pin: pin});
	endtask

	// Flushes the ring, then walks the lockout boundary: an edge exactly at
	// the lockout distance is refused and one tick later it is taken.
	task automatic push_lockout_probe();
		repeat (QUEUE_DEPTH) push_item(CMD_POP, 1'($urandom_range(0, 1)));
		repeat (lockout_now + 1) push_item(CMD_TICK, 1'($urandom_range(0, 1)));
		push_item(CMD_EDGE, 1'b0);
		push_item(CMD_EDGE, 1'b1);
		repeat (lockout_now) push_item(CMD_TICK, 1'($urandom_range(0, 1)));
		push_item(CMD_EDGE, 1'b0);
		push_item(CMD_TICK, 1'b0);
		push_item(CMD_EDGE, 1'b0);
		push_item(CMD_EDGE, 1'b1);
		push_item(CMD_POP, 1'b1);
	endtask

	// Tick runs, bouncing edge bursts and pop runs; the pop share drifts so
	// the ring both fills up and runs dry.
	task automatic push_random_traffic(int unsigned total);
		int unsigned made;
		int unsigned pop_weight;
		int unsigned tick_span;
		int unsigned run;
		int unsigned pick;
		made = 0;
		pop_weight = 20;
		tick_span = (lockout_now < 60) ? lockout_now + 2 : 8;
		while (made < total) begin
			if ($urandom_range(0, 63) == 0)
				pop_weight = $urandom_range(4, 40);
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				push_item(CMD_NONE, 1'($urandom_range(0, 1)));
			end else if (pick < 3 + pop_weight) begin
				run = $urandom_range(1, 3);
				repeat (run) push_item(CMD_POP, 1'($urandom_range(0, 1)));
				made += run;
			end else if (pick < 33 + pop_weight) begin
				run = $urandom_range(1, 4);
				repeat (run) push_item(CMD_EDGE, 1'($urandom_range(0, 1)));
				made += run;
			end else begin
				run = $urandom_range(1, tick_span);
				repeat (run) push_item(CMD_TICK, 1'($urandom_range(0, 1)));
				made += run;
			end
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || start || reports_due.size() != 0);
	endtask

	task automatic write_lockout(logic [LOCKOUT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk);
		while (!(cfg_valid && cfg_ready));
		lockout_now = value;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			command <= CMD_TICK;
			pin_level <= 1'b0;
		end else begin
			if (start && !busy)
				apply_debounce_item(cmd_e_t'(command), pin_level);
			if (start && busy) begin
				// The item stays on the port until it is taken.
			end else if (pending_items.size() != 0 &&
					$urandom_range(0, 99) >= sender_idle_pct) begin
				next_item = pending_items.pop_front();
				start <= 1'b1;
				command <= next_item.cmd;
				pin_level <= next_item.pin;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (reports_due.size() == 0) begin
				$error("result with no item outstanding");
				mismatches++;
			end else begin
				want_report = reports_due.pop_front();
				got_report = '{valid: event_valid, level: event_level, stamp: event_time,
					accepted: edge_accepted, full: queue_full};
				check_field("event_valid", 32'(want_report.valid), 32'(got_report.valid));
				check_field("event_level", 32'(want_report.level), 32'(got_report.level));
				check_field("event_time", want_report.stamp, got_report.stamp);
				check_field("edge_accepted", 32'(want_report.accepted),
					32'(got_report.accepted));
				check_field("queue_full", 32'(want_report.full), 32'(got_report.full));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("debounced_edge_event_fifo_top regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset lockout: empty pop, unused command, same-level edge and an
		// edge inside the lockout window.
		push_item(CMD_POP, 1'b0);
		push_item(CMD_NONE, 1'b1);
		push_item(CMD_NONE, 1'b0);
		push_item(CMD_EDGE, 1'b0);
		push_item(CMD_EDGE, 1'b1);
		push_item(CMD_TICK, 1'b1);
		push_item(CMD_POP, 1'b1);
		push_lockout_probe();
		wait_drained();

		write_lockout('0);
		push_lockout_probe();
		// Fill the ring to its limit, keep hitting it while full, then empty it.
		repeat (QUEUE_DEPTH) begin
			push_item(CMD_TICK, 1'b0);
			push_item(CMD_EDGE, 1'b1);
			push_item(CMD_TICK, 1'b1);
			push_item(CMD_EDGE, 1'b0);
		end
		repeat (QUEUE_DEPTH + 1) push_item(CMD_POP, 1'b0);
		push_random_traffic(300);
		wait_drained();

		foreach (lockout_plan[i]) begin
			sender_idle_pct = idle_plan[i];
			write_lockout(LOCKOUT_W'(lockout_plan[i]));
			// A very long lockout only sees refused edges; walking its boundary
			// would take tens of thousands of ticks.
			if (lockout_plan[i] < 1000)
				push_lockout_probe();
			push_random_traffic(200);
			wait_drained();
		end

		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("debounced_edge_event_fifo_top regression: pass");
		else
			$display("debounced_edge_event_fifo_top regression: fail");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/deef_pkg.sv
hw/rtl/debounced_edge_event_fifo_top.sv
bench/tb_debounced_edge_event_fifo_top.sv
